@@ hw/rtl/nec_pkg.sv @@
`default_nettype none

package nec_pkg;

   // duration and code widths
   localparam int DURATION_BITS = 15;
   localparam int CODE_BITS     = 16;
   localparam int DATA_BITS     = 2 * CODE_BITS;

   // frame lengths in symbols
   localparam int MAX_SYMBOLS  = 64;
   localparam int FULL_COUNT   = 34;
   localparam int REPEAT_COUNT = 2;
   localparam int COUNT_BITS   = $clog2(MAX_SYMBOLS + 1);
   localparam int SHIFT_BITS   = $clog2(DATA_BITS);

   // register file layout
   localparam int CSR_COUNT      = 7;
   localparam int CSR_INDEX_BITS = $clog2(CSR_COUNT);
   localparam int CSR_ADDR_BITS  = CSR_INDEX_BITS + 2;
   localparam int CSR_DATA_BITS  = 32;

   // register reset values
   localparam logic [DURATION_BITS-1:0] TOLERANCE_RESET    = DURATION_BITS'(200);
   localparam logic [DURATION_BITS-1:0] LEADER_MARK_RESET  = DURATION_BITS'(9000);
   localparam logic [DURATION_BITS-1:0] LEADER_SPACE_RESET = DURATION_BITS'(4500);
   localparam logic [DURATION_BITS-1:0] BIT_MARK_RESET     = DURATION_BITS'(560);
   localparam logic [DURATION_BITS-1:0] ZERO_SPACE_RESET   = DURATION_BITS'(560);
   localparam logic [DURATION_BITS-1:0] ONE_SPACE_RESET    = DURATION_BITS'(1690);
   localparam logic [DURATION_BITS-1:0] REPEAT_SPACE_RESET = DURATION_BITS'(2250);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOLERANCE    = 3'd0,
      CSR_LEADER_MARK  = 3'd1,
      CSR_LEADER_SPACE = 3'd2,
      CSR_BIT_MARK     = 3'd3,
      CSR_ZERO_SPACE   = 3'd4,
      CSR_ONE_SPACE    = 3'd5,
      CSR_REPEAT_SPACE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_DECODED     = 2'd0,
      STATUS_REPEAT      = 2'd1,
      STATUS_BAD_TIMING  = 2'd2,
      STATUS_BAD_COUNT   = 2'd3
   } status_type;

   typedef logic [DURATION_BITS-1:0] duration_type;
   typedef logic [CODE_BITS-1:0]     code_type;

endpackage

`default_nettype wire

@@ hw/rtl/nec_req_if.sv @@
`default_nettype none

// symbol channel: one captured mark/space pair per transfer
interface nec_req_if;
   logic                 valid;
   logic                 ready;
   nec_pkg::duration_type mark_ticks;
   nec_pkg::duration_type space_ticks;
   logic                 frame_end;

   modport source (output valid, output mark_ticks, output space_ticks,
                   output frame_end, input ready);
   modport sink   (input valid, input mark_ticks, input space_ticks,
                   input frame_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nec_rsp_if.sv @@
`default_nettype none

// frame result channel: one transfer per completed frame
interface nec_rsp_if;
   logic                 valid;
   logic                 ready;
   nec_pkg::status_type  status;
   nec_pkg::code_type    address_code;
   nec_pkg::code_type    command_code;

   modport source (output valid, output status, output address_code,
                   output command_code, input ready);
   modport sink   (input valid, input status, input address_code,
                   input command_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nec_ir_frame_decoder_core.sv @@
`default_nettype none

// Channel   Dir   Transfer                         Payload
// req       in    valid & ready at clock edge      mark_ticks, space_ticks, frame_end
// rsp       out   valid & ready at clock edge      status, address_code, command_code
// csr (APB) in    psel & penable & pwrite          7 x 15-bit registers at 4*i
//
// One symbol per cycle sustained unless a final symbol waits for the output register:
// a symbol is checked while it sits in the input register, and the frame state and
// result register update at the edge that retires it, which also raises rsp valid.
// reset is synchronous, active high; configuration registers return to their nominal values.
// While a result waits on rsp.ready, non-final symbols keep flowing; a final
// symbol waits in the input register until the output register is free.

module nec_ir_frame_decoder_core (
   input  wire logic clock,
   input  wire logic reset,
   nec_req_if.sink   req,
   nec_rsp_if.source rsp,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [nec_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [nec_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [nec_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);

   // configuration registers
   nec_pkg::duration_type tolerance_ff, leader_mark_ff, leader_space_ff;
   nec_pkg::duration_type bit_mark_ff, zero_space_ff, one_space_ff, repeat_space_ff;
   nec_pkg::csr_index_type csr_index;
   logic                   csr_write;

   // input register
   logic                  in_valid_ff;
   nec_pkg::duration_type in_mark_ff, in_space_ff;
   logic                  in_end_ff;

   // frame state
   logic [nec_pkg::COUNT_BITS-1:0] symbol_index_ff, symbol_index_in;
   logic [nec_pkg::DATA_BITS-1:0]  bit_shift_ff, bit_shift_in;
   logic                           timing_ok_ff, timing_ok_in;
   logic                           repeat_seen_ff, repeat_seen_in;
   nec_pkg::code_type              held_address_ff, held_address_in;
   nec_pkg::code_type              held_command_ff, held_command_in;

   // output register
   logic                 out_valid_ff;
   nec_pkg::status_type  out_status_ff, out_status_in;

   logic out_free, advance;
   logic [nec_pkg::COUNT_BITS-1:0] count_next;
   logic [nec_pkg::SHIFT_BITS-1:0] bit_pos;
   logic mark_lead, space_lead, space_rep, mark_bit, space_one, space_zero;

   // strict window check: nom - tol < d < nom + tol
   function automatic logic near(input nec_pkg::duration_type d,
                                 input nec_pkg::duration_type nom,
                                 input nec_pkg::duration_type tol);
      logic [nec_pkg::DURATION_BITS:0] lo_sum, hi_sum;
      lo_sum = {1'b0, d} + {1'b0, tol};
      hi_sum = {1'b0, nom} + {1'b0, tol};
      return (lo_sum > {1'b0, nom}) && ({1'b0, d} < hi_sum);
   endfunction

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_index = nec_pkg::csr_index_type'(paddr[nec_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff    <= nec_pkg::TOLERANCE_RESET;
         leader_mark_ff  <= nec_pkg::LEADER_MARK_RESET;
         leader_space_ff <= nec_pkg::LEADER_SPACE_RESET;
         bit_mark_ff     <= nec_pkg::BIT_MARK_RESET;
         zero_space_ff   <= nec_pkg::ZERO_SPACE_RESET;
         one_space_ff    <= nec_pkg::ONE_SPACE_RESET;
         repeat_space_ff <= nec_pkg::REPEAT_SPACE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            nec_pkg::CSR_TOLERANCE:    tolerance_ff    <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_LEADER_MARK:  leader_mark_ff  <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_LEADER_SPACE: leader_space_ff <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_BIT_MARK:     bit_mark_ff     <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_ZERO_SPACE:   zero_space_ff   <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_ONE_SPACE:    one_space_ff    <= pwdata[nec_pkg::DURATION_BITS-1:0];
            nec_pkg::CSR_REPEAT_SPACE: repeat_space_ff <= pwdata[nec_pkg::DURATION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux, unused addresses read zero
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         nec_pkg::CSR_TOLERANCE:    prdata = nec_pkg::CSR_DATA_BITS'(tolerance_ff);
         nec_pkg::CSR_LEADER_MARK:  prdata = nec_pkg::CSR_DATA_BITS'(leader_mark_ff);
         nec_pkg::CSR_LEADER_SPACE: prdata = nec_pkg::CSR_DATA_BITS'(leader_space_ff);
         nec_pkg::CSR_BIT_MARK:     prdata = nec_pkg::CSR_DATA_BITS'(bit_mark_ff);
         nec_pkg::CSR_ZERO_SPACE:   prdata = nec_pkg::CSR_DATA_BITS'(zero_space_ff);
         nec_pkg::CSR_ONE_SPACE:    prdata = nec_pkg::CSR_DATA_BITS'(one_space_ff);
         nec_pkg::CSR_REPEAT_SPACE: prdata = nec_pkg::CSR_DATA_BITS'(repeat_space_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // a final symbol needs the output register; other symbols never stall
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && (out_free || !in_end_ff);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_mark_ff  <= req.mark_ticks;
         in_space_ff <= req.space_ticks;
         in_end_ff   <= req.frame_end;
      end
   end

   // ---------------- symbol checks ----------------
   assign mark_lead  = near(in_mark_ff,  leader_mark_ff,  tolerance_ff);
   assign space_lead = near(in_space_ff, leader_space_ff, tolerance_ff);
   assign space_rep  = near(in_space_ff, repeat_space_ff, tolerance_ff);
   assign mark_bit   = near(in_mark_ff,  bit_mark_ff,     tolerance_ff);
   assign space_one  = near(in_space_ff, one_space_ff,    tolerance_ff);
   assign space_zero = near(in_space_ff, zero_space_ff,   tolerance_ff);

   assign bit_pos = nec_pkg::SHIFT_BITS'(symbol_index_ff - 1'b1);

   // ---------------- frame state update ----------------
   always_comb begin
      bit_shift_in    = bit_shift_ff;
      timing_ok_in    = timing_ok_ff;
      repeat_seen_in  = repeat_seen_ff;
      held_address_in = held_address_ff;
      held_command_in = held_command_ff;
      out_status_in   = nec_pkg::STATUS_BAD_COUNT;

      // leader or repeat symbol, then data bits, rest unchecked
      if (symbol_index_ff == '0) begin
         if (!(mark_lead && space_lead)) begin
            timing_ok_in = 1'b0;
         end
         repeat_seen_in = mark_lead && space_rep;
      end else if (symbol_index_ff <= nec_pkg::COUNT_BITS'(nec_pkg::DATA_BITS)) begin
         if (mark_bit && space_one) begin
            bit_shift_in[bit_pos] = 1'b1;
         end else if (!(mark_bit && space_zero)) begin
            timing_ok_in = 1'b0;
         end
      end

      // saturating symbol count
      if (symbol_index_ff < nec_pkg::COUNT_BITS'(nec_pkg::MAX_SYMBOLS)) begin
         count_next = symbol_index_ff + 1'b1;
      end else begin
         count_next = symbol_index_ff;
      end
      symbol_index_in = count_next;

      // frame verdict on the last symbol
      if (in_end_ff) begin
         if (count_next == nec_pkg::COUNT_BITS'(nec_pkg::FULL_COUNT)) begin
            if (timing_ok_in) begin
               held_address_in = bit_shift_in[nec_pkg::CODE_BITS-1:0];
               held_command_in = bit_shift_in[nec_pkg::DATA_BITS-1:nec_pkg::CODE_BITS];
               out_status_in   = nec_pkg::STATUS_DECODED;
            end else begin
               out_status_in   = nec_pkg::STATUS_BAD_TIMING;
            end
         end else if (count_next == nec_pkg::COUNT_BITS'(nec_pkg::REPEAT_COUNT)) begin
            out_status_in = repeat_seen_in ? nec_pkg::STATUS_REPEAT
                                           : nec_pkg::STATUS_BAD_TIMING;
         end else begin
            out_status_in = nec_pkg::STATUS_BAD_COUNT;
         end
         symbol_index_in = '0;
         bit_shift_in    = '0;
         timing_ok_in    = 1'b1;
         repeat_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_index_ff <= '0;
         bit_shift_ff    <= '0;
         timing_ok_ff    <= 1'b1;
         repeat_seen_ff  <= 1'b0;
         held_address_ff <= '0;
         held_command_ff <= '0;
      end else if (advance) begin
         symbol_index_ff <= symbol_index_in;
         bit_shift_ff    <= bit_shift_in;
         timing_ok_ff    <= timing_ok_in;
         repeat_seen_ff  <= repeat_seen_in;
         held_address_ff <= held_address_in;
         held_command_ff <= held_command_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         out_status_ff <= out_status_in;
      end
   end

   // codes always mirror the held registers: they change only with a new result
   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.address_code = held_address_ff;
   assign rsp.command_code = held_command_ff;

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      symbol_index_ff <= nec_pkg::COUNT_BITS'(nec_pkg::MAX_SYMBOLS))
      else $error("symbol count past saturation");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> symbol_index_ff == '0 && timing_ok_ff && !repeat_seen_ff)
      else $error("frame state not cleared after frame end");

   a_final_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_end_ff && out_valid_ff && !rsp.ready |=> in_valid_ff && in_end_ff)
      else $error("final symbol dropped while result stalled");

   a_codes_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> $stable(held_address_ff) && $stable(held_command_ff))
      else $error("held codes changed under a pending result");

   a_decode_bits: assert property (@(posedge clock) disable iff (reset)
      advance && !in_end_ff && symbol_index_ff == '0 |=> bit_shift_ff == '0)
      else $error("data bits gathered on leader symbol");

endmodule

`default_nettype wire
